### rtl/intw_pkg.sv
package intw_pkg;

   localparam int VALUE_W     = 31;
   localparam int WORD_W      = 5;
   localparam int NUM_DIGITS  = 10;
   localparam int SHIFT_W     = 32;
   localparam int CONV_STEPS  = SHIFT_W / 2;
   localparam int STEP_CNT_W  = $clog2(CONV_STEPS);
   localparam int GROUP_SLOTS = 5;
   localparam int NUM_SLOTS   = 4 * GROUP_SLOTS;
   localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);
   localparam int QUEUE_DEPTH = 2;

   typedef logic [3:0]               digit_type;
   typedef digit_type [NUM_DIGITS-1:0] bcd_type;
   typedef logic [WORD_W-1:0]        word_type;
   typedef word_type [NUM_SLOTS-1:0] slot_word_type;
   typedef logic [NUM_SLOTS-1:0]     slot_mask_type;
   typedef word_type [GROUP_SLOTS-1:0] grp_word_type;
   typedef logic [GROUP_SLOTS-1:0]   grp_mask_type;

   typedef struct packed {
      slot_word_type words;
      slot_mask_type mask;
   } slots_type;

   typedef struct packed {
      grp_word_type words;
      grp_mask_type mask;
   } grp_slots_type;

   localparam word_type TOK_ZERO      = 5'd0;
   localparam word_type TOK_TEEN_BASE = 5'd10;
   localparam word_type TOK_TENS_BASE = 5'd18;
   localparam word_type TOK_HUNDRED   = 5'd28;
   localparam word_type TOK_THOUSAND  = 5'd29;
   localparam word_type TOK_MILLION   = 5'd30;
   localparam word_type TOK_BILLION   = 5'd31;

   // one double-dabble step: add 3 to digits above 4, then shift in one bit
   function automatic bcd_type dabble(input bcd_type d, input logic b);
      bcd_type     adj;
      logic [39:0] flat;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
      end
      flat = adj;
      return bcd_type'({flat[38:0], b});
   endfunction

   // slot order within a group: hundreds digit, hundred, tens or teen, ones, scale
   function automatic grp_slots_type group_slots(input digit_type h, input digit_type t,
                                                 input digit_type o, input word_type scale,
                                                 input logic has_scale);
      grp_slots_type s;
      logic          nz;
      nz = (h != 4'd0) || (t != 4'd0) || (o != 4'd0);
      s.words[0] = {1'b0, h};
      s.mask[0]  = h != 4'd0;
      s.words[1] = TOK_HUNDRED;
      s.mask[1]  = h != 4'd0;
      if (t == 4'd1) begin
         s.words[2] = TOK_TEEN_BASE + {1'b0, o};
         s.mask[2]  = 1'b1;
      end else begin
         s.words[2] = TOK_TENS_BASE + {1'b0, t};
         s.mask[2]  = t >= 4'd2;
      end
      s.words[3] = {1'b0, o};
      s.mask[3]  = (o != 4'd0) && (t != 4'd1);
      s.words[4] = scale;
      s.mask[4]  = nz && has_scale;
      return s;
   endfunction

   function automatic slots_type build_slots(input bcd_type d);
      slots_type     s;
      grp_slots_type g0, g1, g2, g3;
      g0 = group_slots(4'd0, 4'd0, d[9], TOK_BILLION, 1'b1);
      g1 = group_slots(d[8], d[7], d[6], TOK_MILLION, 1'b1);
      g2 = group_slots(d[5], d[4], d[3], TOK_THOUSAND, 1'b1);
      g3 = group_slots(d[2], d[1], d[0], TOK_ZERO, 1'b0);
      s.words = {g3.words, g2.words, g1.words, g0.words};
      s.mask  = {g3.mask, g2.mask, g1.mask, g0.mask};
      // a zero value says Zero through the units ones slot
      if (d == '0) begin
         s.mask[3*GROUP_SLOTS+3] = 1'b1;
      end
      return s;
   endfunction

endpackage

### rtl/intw_front.sv
module intw_front import intw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   output logic               push,
   output bcd_type            push_digits,
   input  logic               q_full
);

   logic                  busy_ff, busy_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SHIFT_W-1:0]    sh_ff, sh_in;
   bcd_type               bcd_ff, bcd_in;
   bcd_type               step_bcd;
   logic                  last_step, advance, accept;

   always_comb begin
      step_bcd  = dabble(dabble(bcd_ff, sh_ff[SHIFT_W-1]), sh_ff[SHIFT_W-2]);
      last_step = cnt_ff == STEP_CNT_W'(CONV_STEPS - 1);
      push      = busy_ff && last_step && !q_full;
      advance   = busy_ff && !(last_step && q_full);
      req_stall = busy_ff && !push;
      accept    = req_valid && !req_stall;
      push_digits = step_bcd;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      bcd_in  = bcd_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = {{(SHIFT_W-VALUE_W){1'b0}}, req_value};
         bcd_in  = '0;
      end else if (advance) begin
         cnt_in = cnt_ff + 1'b1;
         sh_in  = {sh_ff[SHIFT_W-3:0], 2'b00};
         bcd_in = step_bcd;
         if (push) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      bcd_ff <= bcd_in;
   end

endmodule

### rtl/intw_queue.sv
module intw_queue import intw_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  bcd_type push_digits,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output bcd_type head_digits
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bcd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      full        = cnt_ff == CNT_W'(DEPTH);
      head_valid  = cnt_ff != '0;
      head_digits = mem_ff[rd_ff];
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_digits;
      end
   end

endmodule

### rtl/intw_back.sv
module intw_back import intw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  bcd_type           head_digits,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_word,
   output logic              rsp_last
);

   slot_word_type         words_ff, words_in;
   slot_mask_type         mask_ff, mask_in;
   slots_type             head_slots;
   logic [SLOT_IDX_W-1:0] idx;
   logic                  accept;

   always_comb begin
      // lowest pending slot is the next word
      idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            idx = SLOT_IDX_W'(i);
         end
      end
      rsp_valid = mask_ff != '0;
      rsp_word  = words_ff[idx];
      rsp_last  = (mask_ff & (mask_ff - 1'b1)) == '0;
      accept    = rsp_valid && !rsp_stall;
      pop       = head_valid && (!rsp_valid || (accept && rsp_last));

      head_slots = build_slots(head_digits);
      words_in   = words_ff;
      mask_in    = mask_ff;
      if (pop) begin
         words_in = head_slots.words;
         mask_in  = head_slots.mask;
      end else if (accept) begin
         mask_in = mask_ff & (mask_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      words_ff <= words_in;
   end

endmodule

### rtl/integer_to_english_word_tokens.sv
// Spells a 31-bit unsigned value as English word tokens, one token per rsp
// transaction, with rsp_last on the final token (Zero alone for a zero value).
// The front converts the value to ten decimal digits by shift-and-add-3, two
// bits per cycle (the last step waits while the queue is full), and takes a
// new value in the cycle it pushes digits. Digits pass through a small queue
// to the back, which emits one token per cycle with no gaps while rsp_stall
// is low and the queue holds digits, up to 16 tokens per value.
module integer_to_english_word_tokens import intw_pkg::*; #(
   parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [WORD_W-1:0]  rsp_word,
   output logic               rsp_last
);

   logic    push, q_full, pop, head_valid;
   bcd_type push_digits, head_digits;

   intw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .push        (push),
      .push_digits (push_digits),
      .q_full      (q_full)
   );

   intw_queue #(
      .DEPTH (QUEUE_ENTRIES)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_digits (push_digits),
      .full        (q_full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_digits (head_digits)
   );

   intw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_digits (head_digits),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .rsp_last    (rsp_last)
   );

endmodule

### sim/word_token_checker.sv
module word_token_checker import intw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [WORD_W-1:0]  rsp_word,
   input  logic               rsp_last,
   output int                 error_count,
   output int                 tokens_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      word_type word;
      logic     last;
   } token_entry;

   token_entry expected_tokens[$];

   // spell one value into its word tokens, appended to the expected queue
   function automatic void spell_value(input logic [VALUE_W-1:0] value);
      int unsigned scale_div [4] = '{1000000000, 1000000, 1000, 1};
      word_type    scale_word [4] = '{TOK_BILLION, TOK_MILLION, TOK_THOUSAND, TOK_ZERO};
      int unsigned v;
      int unsigned grp;
      int unsigned hundreds;
      int unsigned rest;
      word_type    words[$];
      token_entry  entry;
      v = value;
      if (v == 0) begin
         words.push_back(TOK_ZERO);
      end
      for (int i = 0; i < 4; i++) begin
         grp = (v / scale_div[i]) % 1000;
         if (grp != 0) begin
            hundreds = grp / 100;
            rest     = grp % 100;
            if (hundreds != 0) begin
               words.push_back(word_type'(hundreds));
               words.push_back(TOK_HUNDRED);
            end
            if (rest != 0 && rest < 20) begin
               words.push_back(word_type'(rest));
            end else if (rest >= 20) begin
               words.push_back(TOK_TENS_BASE + word_type'(rest / 10));
               if (rest % 10 != 0) begin
                  words.push_back(word_type'(rest % 10));
               end
            end
            if (i < 3) begin
               words.push_back(scale_word[i]);
            end
         end
      end
      foreach (words[k]) begin
         entry.word = words[k];
         entry.last = (k == words.size() - 1);
         expected_tokens.push_back(entry);
      end
   endfunction

   int         reported;
   token_entry oldest;

   initial begin
      error_count    = 0;
      tokens_waiting = 0;
      reported       = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         // check the outgoing token before queueing anything new
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               error_count++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: unexpected token word=%0d last=%0b", $realtime,
                           rsp_word, rsp_last);
               end
            end else begin
               oldest = expected_tokens.pop_front();
               if (rsp_word !== oldest.word || rsp_last !== oldest.last) begin
                  error_count++;
                  if (reported < 10) begin
                     reported++;
                     $display("%0t: token mismatch: expected word=%0d last=%0b,",
                              $realtime, oldest.word, oldest.last,
                              " got word=%0d last=%0b", rsp_word, rsp_last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            spell_value(req_value);
         end
      end
      tokens_waiting = expected_tokens.size();
   end

endmodule

### sim/integer_to_english_word_tokens_test.sv
module integer_to_english_word_tokens_test import intw_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PER_PHASE = 75;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [WORD_W-1:0]  rsp_word;
   logic               rsp_last;
   int                 error_count;
   int                 tokens_waiting;

   int idle_pct;
   int stall_pct;

   integer_to_english_word_tokens u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

   word_token_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .rsp_last       (rsp_last),
      .error_count    (error_count),
      .tokens_waiting (tokens_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one three-digit group, biased toward teens, round tens and hundreds
   function automatic int unsigned pick_group();
      case ($urandom_range(7))
         0: return 0;
         1: return $urandom_range(19, 10);
         2: return 10 * $urandom_range(9, 2);
         3: return 100 * $urandom_range(9, 1);
         4: return 100 * $urandom_range(9, 1) + $urandom_range(19, 10);
         5: return $urandom_range(9, 1);
         default: return $urandom_range(999);
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      longint total;
      int     pick;
      pick = $urandom_range(99);
      if (pick < 25) begin
         return VALUE_W'($urandom());
      end else if (pick < 40) begin
         return VALUE_W'($urandom_range(1999));
      end
      total = longint'($urandom_range(2)) * 1000000000 + longint'(pick_group()) * 1000000
              + longint'(pick_group()) * 1000 + longint'(pick_group());
      if (total > 2147483647) begin
         total -= 1000000000;
      end
      return total[VALUE_W-1:0];
   endfunction

   task automatic send_value(input logic [VALUE_W-1:0] value);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   logic [VALUE_W-1:0] directed [$] = '{
      0, 1, 9, 10, 11, 19, 20, 21, 70, 99, 100, 101, 110, 999, 1000, 1001,
      700000, 1000000, 20020020, 123456789, 1000000000, 1010010010,
      1777777777, 2000000000, 2147483647
   };

   int idle_sets  [4] = '{0, 66, 0, 30};
   int stall_sets [4] = '{0, 0, 66, 30};

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      rsp_stall = 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_value(directed[i]);
      end
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_sets[phase];
         stall_pct = stall_sets[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_value(random_value());
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      wait (tokens_waiting == 0);
      // latency margin to catch stray tokens
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
